[rtl/bocb_pkg.sv]
// Shared types and constants for the BWT occurrence checkpoint builder.
// No dependencies; imported by bwt_occurrence_checkpoint_builder.
package bocb_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int SPACING_WIDTH       = 16;
  localparam int FIELD_WIDTH         = 32;
  localparam int FLAG_WIDTH          = 2;

  localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 16'd1;

  // lower-case codes; a symbol OR 0x20 matches either case
  localparam logic [7:0] SYM_A_LOWER = 8'h61;
  localparam logic [7:0] SYM_C_LOWER = 8'h63;
  localparam logic [7:0] SYM_G_LOWER = 8'h67;
  localparam logic [7:0] SYM_T_LOWER = 8'h74;
  localparam logic [7:0] SYM_N_LOWER = 8'h6E;
  localparam logic [7:0] SYM_DOLLAR  = 8'h24;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  localparam int FLAG_N_SEEN   = 0;
  localparam int FLAG_UNKNOWN  = 1;

  localparam int ROW_ZERO    = 0;
  localparam int ROW_CKPT    = 1;
  localparam int ROW_SUMMARY = 2;
  localparam int ROW_COUNT   = 3;

  typedef enum logic [1:0] {
    KIND_ZERO       = 2'd0,
    KIND_CHECKPOINT = 2'd1,
    KIND_SUMMARY    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ROW_COUNT-1:0]   emit;
    logic [FIELD_WIDTH-1:0] count_a;
    logic [FIELD_WIDTH-1:0] count_c;
    logic [FIELD_WIDTH-1:0] count_g;
    logic [FIELD_WIDTH-1:0] count_t;
    logic [FIELD_WIDTH-1:0] start_c;
    logic [FIELD_WIDTH-1:0] start_g;
    logic [FIELD_WIDTH-1:0] start_t;
    logic [FIELD_WIDTH-1:0] start_end;
    logic [FIELD_WIDTH-1:0] dollar_position;
    logic [FLAG_WIDTH-1:0]  flags;
  } row_set_t;

endpackage

[rtl/bwt_occurrence_checkpoint_builder.sv]
// Occurrence checkpoint builder: counts A/C/G/T over a BWT string and emits
// zero, checkpoint and summary rows. Depends on bocb_pkg.
//
// Timing: an item's first row is registered in the row queue and is valid
// in the cycle after the item is taken when the queue is empty; queued rows
// ahead of it and output stalls delay it. Throughput: one item per cycle
// while each item gives one row and the output does not stall; an item with
// several rows holds the output until all are taken. A two-entry row queue
// separates input from output, so input stalls only when both entries hold.
// Reset (rst, synchronous): counts, phase, position, flags and queue clear;
// the stored spacing returns to 1. After each summary row the string state
// clears again and the spacing keeps its value.
module bwt_occurrence_checkpoint_builder #(
  parameter int COUNT_WIDTH = bocb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bocb_pkg::SPACING_WIDTH-1:0]  checkpoint_spacing,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          symbol,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    count_a,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    count_c,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    count_g,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    count_t,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    start_c,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    start_g,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    start_t,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    start_end,
  output logic [bocb_pkg::FIELD_WIDTH-1:0]    dollar_position,
  output logic [bocb_pkg::FLAG_WIDTH-1:0]     flags,
  output logic                                last_of_run
);
  import bocb_pkg::*;

  localparam logic [COUNT_WIDTH-1:0]  COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [FIELD_WIDTH-1:0]  POS_MAX   = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                     input logic en);
    logic [COUNT_WIDTH-1:0] r;
    r = v;
    if (en && (v != '1)) begin
      r = v + COUNT_ONE;
    end
    return r;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] clamp32(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w[63:32] != 32'd0) ? POS_MAX : w[31:0];
  endfunction

  logic [SPACING_WIDTH-1:0] spacing;
  logic [COUNT_WIDTH-1:0]   tally_a, tally_c, tally_g, tally_t;
  logic [COUNT_WIDTH-1:0]   sum_c, sum_g, sum_t, sum_end;
  logic [SPACING_WIDTH-1:0] spacing_phase;
  logic [FIELD_WIDTH-1:0]   symbol_position;
  logic [FIELD_WIDTH-1:0]   dollar_mark;
  logic [FLAG_WIDTH-1:0]    seen_flags;
  logic                     started;

  row_set_t                 queue [2];
  logic                     wr_ptr, rd_ptr;
  logic [1:0]               fill;
  logic [ROW_COUNT-1:0]     sent;

  logic [COUNT_WIDTH-1:0]   tally_a_next, tally_c_next, tally_g_next, tally_t_next;
  logic [COUNT_WIDTH-1:0]   sum_c_next, sum_g_next, sum_t_next, sum_end_next;
  logic [SPACING_WIDTH-1:0] spacing_phase_next;
  logic [FIELD_WIDTH-1:0]   symbol_position_next;
  logic [FIELD_WIDTH-1:0]   dollar_mark_next;
  logic [FLAG_WIDTH-1:0]    seen_flags_next;
  logic [SPACING_WIDTH:0]   phase_inc;
  logic [SPACING_WIDTH-1:0] spacing_eff;
  logic [7:0]               sym_fold;
  logic                     is_a, is_c, is_g, is_t, is_n, is_dollar;
  row_set_t                 row_new;
  logic                     take, push, pop, out_take;
  row_set_t                 head;
  logic [ROW_COUNT-1:0]     remaining, sel;

  assign cfg_ready = 1'b1;
  assign in_stall  = (fill == 2'd2);
  assign take      = in_valid && !in_stall;

  always_comb begin
    sym_fold  = symbol | CASE_BIT;
    is_a      = (sym_fold == SYM_A_LOWER);
    is_c      = (sym_fold == SYM_C_LOWER);
    is_g      = (sym_fold == SYM_G_LOWER);
    is_t      = (sym_fold == SYM_T_LOWER);
    is_n      = (sym_fold == SYM_N_LOWER);
    is_dollar = (symbol == SYM_DOLLAR);

    tally_a_next = sat_inc(tally_a, is_a);
    tally_c_next = sat_inc(tally_c, is_c);
    tally_g_next = sat_inc(tally_g, is_g);
    tally_t_next = sat_inc(tally_t, is_t);
    sum_c_next   = sat_inc(sum_c, is_a);
    sum_g_next   = sat_inc(sum_g, is_a || is_c);
    sum_t_next   = sat_inc(sum_t, is_a || is_c || is_g);
    sum_end_next = sat_inc(sum_end, is_a || is_c || is_g || is_t);

    seen_flags_next = seen_flags;
    seen_flags_next[FLAG_N_SEEN] = seen_flags[FLAG_N_SEEN] | is_n;
    seen_flags_next[FLAG_UNKNOWN] = seen_flags[FLAG_UNKNOWN] |
        !(is_a || is_c || is_g || is_t || is_n || is_dollar);

    symbol_position_next = (symbol_position == POS_MAX) ? POS_MAX
                                                         : symbol_position + 32'd1;
    dollar_mark_next = is_dollar ? symbol_position_next : dollar_mark;

    spacing_eff = (spacing == '0) ? SPACING_RESET : spacing;
    phase_inc   = {1'b0, spacing_phase} + {{SPACING_WIDTH{1'b0}}, 1'b1};
    spacing_phase_next = (phase_inc >= {1'b0, spacing_eff}) ? '0
                                                            : phase_inc[SPACING_WIDTH-1:0];

    row_new.emit[ROW_ZERO]    = !started;
    row_new.emit[ROW_CKPT]    = (spacing_phase == '0);
    row_new.emit[ROW_SUMMARY] = last;
    row_new.count_a         = clamp32(tally_a_next);
    row_new.count_c         = clamp32(tally_c_next);
    row_new.count_g         = clamp32(tally_g_next);
    row_new.count_t         = clamp32(tally_t_next);
    row_new.start_c         = clamp32(sum_c_next);
    row_new.start_g         = clamp32(sum_g_next);
    row_new.start_t         = clamp32(sum_t_next);
    row_new.start_end       = clamp32(sum_end_next);
    row_new.dollar_position = dollar_mark_next;
    row_new.flags           = seen_flags_next;
  end

  assign push = take && (row_new.emit != '0);

  always_comb begin
    head      = queue[rd_ptr];
    remaining = head.emit & ~sent;
    if (remaining[ROW_ZERO]) begin
      sel = ROW_COUNT'(1) << ROW_ZERO;
    end else if (remaining[ROW_CKPT]) begin
      sel = ROW_COUNT'(1) << ROW_CKPT;
    end else begin
      sel = ROW_COUNT'(1) << ROW_SUMMARY;
    end
  end

  assign out_valid   = (fill != 2'd0);
  assign last_of_run = (remaining == sel);
  assign out_take    = out_valid && !out_stall;
  assign pop         = out_take && last_of_run;

  always_comb begin
    kind            = KIND_SUMMARY;
    count_a         = head.count_a;
    count_c         = head.count_c;
    count_g         = head.count_g;
    count_t         = head.count_t;
    start_c         = '0;
    start_g         = '0;
    start_t         = '0;
    start_end       = '0;
    dollar_position = '0;
    flags           = head.flags;
    if (sel[ROW_ZERO]) begin
      kind    = KIND_ZERO;
      count_a = '0;
      count_c = '0;
      count_g = '0;
      count_t = '0;
      flags   = '0;
    end else if (sel[ROW_CKPT]) begin
      kind = KIND_CHECKPOINT;
    end else begin
      start_c         = head.start_c;
      start_g         = head.start_g;
      start_t         = head.start_t;
      start_end       = head.start_end;
      dollar_position = head.dollar_position;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing         <= SPACING_RESET;
      tally_a         <= '0;
      tally_c         <= '0;
      tally_g         <= '0;
      tally_t         <= '0;
      sum_c           <= COUNT_ONE;
      sum_g           <= COUNT_ONE;
      sum_t           <= COUNT_ONE;
      sum_end         <= COUNT_ONE;
      spacing_phase   <= '0;
      symbol_position <= '0;
      dollar_mark     <= '0;
      seen_flags      <= '0;
      started         <= 1'b0;
      wr_ptr          <= 1'b0;
      rd_ptr          <= 1'b0;
      fill            <= 2'd0;
      sent            <= '0;
    end else begin
      if (cfg_valid) begin
        spacing <= checkpoint_spacing;
      end
      if (take) begin
        if (last) begin
          tally_a         <= '0;
          tally_c         <= '0;
          tally_g         <= '0;
          tally_t         <= '0;
          sum_c           <= COUNT_ONE;
          sum_g           <= COUNT_ONE;
          sum_t           <= COUNT_ONE;
          sum_end         <= COUNT_ONE;
          spacing_phase   <= '0;
          symbol_position <= '0;
          dollar_mark     <= '0;
          seen_flags      <= '0;
          started         <= 1'b0;
        end else begin
          tally_a         <= tally_a_next;
          tally_c         <= tally_c_next;
          tally_g         <= tally_g_next;
          tally_t         <= tally_t_next;
          sum_c           <= sum_c_next;
          sum_g           <= sum_g_next;
          sum_t           <= sum_t_next;
          sum_end         <= sum_end_next;
          spacing_phase   <= spacing_phase_next;
          symbol_position <= symbol_position_next;
          dollar_mark     <= dollar_mark_next;
          seen_flags      <= seen_flags_next;
          started         <= 1'b1;
        end
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        sent   <= '0;
      end else if (out_take) begin
        sent <= sent | sel;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
